// ===== design/glos_pkg.sv =====
// Shared types and constants of the grid line-of-sight unit.
package glos_pkg;

  // Width of every coordinate field on the ports.
  localparam int unsigned CW = 6;
  // Signed width of a crossing coordinate (one below zero is possible).
  localparam int unsigned MW = CW + 2;
  // Signed width of the crossing remainder, step and divisor.
  localparam int unsigned RW = CW + 5;

  localparam int unsigned MAP_ROWS_DEF = 64;
  localparam int unsigned MAP_COLS_DEF = 64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SETUP,
    S_NORM,
    S_CHK_RD,
    S_CHK_EV,
    S_ADJ_RD,
    S_ADJ_EV,
    S_DONE
  } glos_state_e;

  // Request from the sequencer to the map store.
  typedef struct packed {
    logic signed [MW-1:0] rd_row;
    logic signed [MW-1:0] rd_col;
    logic                 wr_en;
    logic [CW-1:0]        wr_row;
    logic [CW-1:0]        wr_col;
    logic                 wr_data;
  } map_req_t;

endpackage

// ===== design/glos_map.sv =====
// Blocking map store with a clearing sweep after reset.
module glos_map import glos_pkg::*; #(
  parameter int unsigned MAP_ROWS = MAP_ROWS_DEF,
  parameter int unsigned MAP_COLS = MAP_COLS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output logic     blocked_o,
  output logic     busy_o
);

  localparam int unsigned DEPTH = MAP_ROWS * MAP_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_cnt_q;
  logic          clr_busy_q;
  logic          rd_q;
  logic          oob_q;
  logic          rd_oob;
  logic          wr_ok;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Cells outside the map read as blocking.
  assign rd_oob = (req_i.rd_row < 0) || (req_i.rd_col < 0) ||
                  (int'(req_i.rd_row) >= int'(MAP_ROWS)) ||
                  (int'(req_i.rd_col) >= int'(MAP_COLS));
  assign wr_ok  = (int'(req_i.wr_row) < int'(MAP_ROWS)) &&
                  (int'(req_i.wr_col) < int'(MAP_COLS));

  assign rd_addr = AW'(unsigned'(req_i.rd_row)) * AW'(MAP_COLS) +
                   AW'(unsigned'(req_i.rd_col));
  assign wr_addr = AW'(req_i.wr_row) * AW'(MAP_COLS) + AW'(req_i.wr_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= 1'b0;
    end else if (req_i.wr_en && wr_ok) begin
      mem[wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= mem[rd_addr];
    oob_q <= rd_oob;
  end

  assign blocked_o = oob_q | rd_q;
  assign busy_o    = clr_busy_q;

endmodule

// ===== design/grid_line_of_sight_unit.sv =====
// A write is taken while the sequencer is idle. A query passes a start state, a set-up state
// for each pass of a diagonal, then a read and an evaluate state per cell on a straight line, or
// per boundary crossing a remainder fold per cell the crossing point moves sideways, a read and
// check, and on a blocked exact corner a check of the cell beside it; the result then waits
// in the output register while stalled. Throughput: one item at a time; the next is taken when
// the sequencer is idle again. Reset: asynchronous and active low; afterwards the map is swept
// clear cell by cell, and no item is accepted until the sweep is over.
module grid_line_of_sight_unit import glos_pkg::*; #(
  parameter int unsigned MAP_ROWS = MAP_ROWS_DEF,
  parameter int unsigned MAP_COLS = MAP_COLS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          command_i,
  input  logic [CW-1:0] cell_row_i,
  input  logic [CW-1:0] cell_col_i,
  input  logic          cell_blocks_i,
  input  logic [CW-1:0] from_row_i,
  input  logic [CW-1:0] from_col_i,
  input  logic [CW-1:0] to_row_i,
  input  logic [CW-1:0] to_col_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          visible_o
);

  // The line is held in half-cell units. For each pass the sequencer walks the
  // major axis one boundary at a time and keeps the minor coordinate as an
  // integer part plus a remainder over a fixed divisor, so no division is needed:
  // a single adder either adds the slope step or folds the remainder back by
  // one divisor per cycle.

  glos_state_e state_q, state_d;

  logic [CW-1:0]        r1_q, c1_q, r2_q, c2_q;
  logic                 pass_q;
  logic                 vis_q;
  logic signed [MW-1:0] major_q, end_q, minor_q, prev_q;
  logic signed [RW-1:0] rem_q, d_q, step_q;
  logic                 out_valid_q, visible_q;

  map_req_t map_req;
  logic     blocked;
  logic     map_busy;
  logic     in_acc;
  logic     query_oob;

  logic signed [RW-1:0] r1s, c1s, r2s, c2s;
  logic signed [RW-1:0] a_maj, a_min, b_maj, b_min;
  logic signed [RW-1:0] su_d, su_rem, su_step, su_prev;
  logic signed [RW-1:0] add_b, add_sum;
  logic                 norm_done, last, prev_fail, chk_fail;
  logic signed [MW-1:0] minor_eff;

  glos_map #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) u_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (map_req),
    .blocked_o(blocked),
    .busy_o   (map_busy)
  );

  assign in_acc = in_valid_i && !in_stall_o;

  assign r1s = signed'(RW'(r1_q));
  assign c1s = signed'(RW'(c1_q));
  assign r2s = signed'(RW'(r2_q));
  assign c2s = signed'(RW'(c2_q));

  assign query_oob = (int'(r1_q) >= int'(MAP_ROWS)) || (int'(r2_q) >= int'(MAP_ROWS)) ||
                     (int'(c1_q) >= int'(MAP_COLS)) || (int'(c2_q) >= int'(MAP_COLS));

  // Pass set-up: endpoint A has the smaller major coordinate. The first
  // boundary lies half a cell past A's centre, which gives the remainder below.
  always_comb begin
    if (!pass_q) begin
      if (r2s < r1s) begin
        a_maj = r2s; a_min = c2s; b_maj = r1s; b_min = c1s;
      end else begin
        a_maj = r1s; a_min = c1s; b_maj = r2s; b_min = c2s;
      end
    end else begin
      if (c2s < c1s) begin
        a_maj = c2s; a_min = r2s; b_maj = c1s; b_min = r1s;
      end else begin
        a_maj = c1s; a_min = r1s; b_maj = c2s; b_min = r2s;
      end
    end
    su_d    = (b_maj - a_maj) <<< 2;
    su_rem  = ((b_maj - a_maj) + (b_min - a_min)) <<< 1;
    su_step = (b_min - a_min) <<< 2;
    su_prev = (a_min > b_min) ? a_min : b_min;
  end

  // The shared adder: remainder plus step, or a fold by one divisor.
  assign norm_done = (rem_q >= 0) && (rem_q < d_q);
  always_comb begin
    if (state_q == S_NORM) begin
      add_b = (rem_q < 0) ? d_q : -d_q;
    end else begin
      add_b = step_q;
    end
  end
  assign add_sum = rem_q + add_b;

  assign last      = (major_q == end_q);
  // Row pass: an earlier crossing column below this one fails; column pass the reverse.
  assign prev_fail = pass_q ? (prev_q > minor_q) : (prev_q < minor_q);
  assign chk_fail  = (rem_q != 0) || prev_fail;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (command_i == CMD_QUERY)) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (query_oob) begin
          state_d = S_DONE;
        end else if ((r1_q == r2_q) || (c1_q == c2_q)) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        if (blocked || last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SETUP: state_d = S_NORM;
      S_NORM: begin
        if (norm_done) begin
          state_d = S_CHK_RD;
        end
      end
      S_CHK_RD: state_d = S_CHK_EV;
      S_CHK_EV: begin
        if (blocked) begin
          state_d = chk_fail ? S_DONE : S_ADJ_RD;
        end else if (last) begin
          state_d = pass_q ? S_DONE : S_SETUP;
        end else begin
          state_d = S_NORM;
        end
      end
      S_ADJ_RD: state_d = S_ADJ_EV;
      S_ADJ_EV: begin
        if (blocked) begin
          state_d = S_DONE;
        end else if (last) begin
          state_d = pass_q ? S_DONE : S_SETUP;
        end else begin
          state_d = S_NORM;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs to the ports and the map.
  always_comb begin
    in_stall_o        = (state_q != S_IDLE) || map_busy;
    minor_eff         = (state_q == S_ADJ_RD) ? (minor_q - MW'(1)) : minor_q;
    map_req.rd_row    = pass_q ? minor_eff : major_q;
    map_req.rd_col    = pass_q ? major_q : minor_eff;
    map_req.wr_en     = in_acc && (command_i == CMD_WRITE);
    map_req.wr_row    = cell_row_i;
    map_req.wr_col    = cell_col_i;
    map_req.wr_data   = cell_blocks_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          r1_q <= from_row_i;
          c1_q <= from_col_i;
          r2_q <= to_row_i;
          c2_q <= to_col_i;
        end
      end
      S_START: begin
        vis_q <= !query_oob;
        if (r1_q == r2_q) begin
          pass_q  <= 1'b1;
          minor_q <= MW'(r1s);
          major_q <= MW'((c1s < c2s) ? c1s : c2s);
          end_q   <= MW'((c1s < c2s) ? c2s : c1s);
        end else begin
          pass_q  <= 1'b0;
          minor_q <= MW'(c1s);
          major_q <= MW'((r1s < r2s) ? r1s : r2s);
          end_q   <= MW'((r1s < r2s) ? r2s : r1s);
        end
      end
      S_SCAN_EV: begin
        if (blocked) begin
          vis_q <= 1'b0;
        end
        major_q <= major_q + MW'(1);
      end
      S_SETUP: begin
        major_q <= MW'(a_maj + RW'(1));
        end_q   <= MW'(b_maj);
        minor_q <= MW'(a_min);
        prev_q  <= MW'(su_prev);
        rem_q   <= su_rem;
        d_q     <= su_d;
        step_q  <= su_step;
      end
      S_NORM: begin
        if (!norm_done) begin
          rem_q   <= add_sum;
          minor_q <= (rem_q < 0) ? (minor_q - MW'(1)) : (minor_q + MW'(1));
        end
      end
      S_CHK_EV, S_ADJ_EV: begin
        if (blocked && ((state_q == S_ADJ_EV) || chk_fail)) begin
          vis_q <= 1'b0;
        end else if (!blocked || (state_q == S_ADJ_EV)) begin
          prev_q <= minor_q;
          if (last) begin
            pass_q <= 1'b1;
          end else begin
            major_q <= major_q + MW'(1);
            rem_q   <= add_sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      visible_q <= vis_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  // The map sweep keeps the input side closed.
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_busy |-> in_stall_o)
    else $error("item accepted during map clear");

  // A crossing is only checked with a fully folded remainder.
  a_rem_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK_EV) |-> ((rem_q >= 0) && (rem_q < d_q)))
    else $error("crossing remainder out of range");

  // A result appears only from the final state of a query.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result without a finished query");

endmodule

// ===== sim/grid_line_of_sight_unit_test.sv =====
// Self-checking testbench of the grid line-of-sight unit: map writes and visibility queries.
module grid_line_of_sight_unit_test import glos_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  // The limit must outlast the clearing sweep after reset and a long query.
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1250;

  // One row of the directed table. The check flag says the visible bit is typed in.
  typedef struct {
    logic       command;
    logic [5:0] cell_row, cell_col;
    logic       cell_blocks;
    logic [5:0] from_row, from_col, to_row, to_col;
    bit         check;
    logic       visible;
  } los_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command = CMD_WRITE;
  logic [5:0] cell_row = '0, cell_col = '0, from_row = '0, from_col = '0;
  logic [5:0] to_row = '0, to_col = '0;
  logic       cell_blocks = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       visible;

  // Private copy of the map as the unit should hold it.
  bit   shadow_map [ROWS][COLS];
  logic visible_due [$];
  int   mismatches = 0;
  int   queries_seen = 0, writes_sent = 0, visible_count = 0;
  int   idle_cycles = 0;
  bit   quiet_sink = 1'b0;

  grid_line_of_sight_unit #(.MAP_ROWS(ROWS), .MAP_COLS(COLS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .cell_row_i(cell_row), .cell_col_i(cell_col),
    .cell_blocks_i(cell_blocks), .from_row_i(from_row), .from_col_i(from_col),
    .to_row_i(to_row), .to_col_i(to_col),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .visible_o(visible)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Anything outside the map counts as blocking.
  function automatic bit is_blocked(longint r, longint c);
    if (r < 0 || c < 0 || r >= ROWS || c >= COLS) return 1'b1;
    return shadow_map[r][c];
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Exact sight test in half-cell units: cell centres sit at 2k+1.
  function automatic bit sight_clear(longint r1, longint c1, longint r2, longint c2);
    longint rlo, rhi, clo, chi, x1, y1, x2, y2, n, d, j, last;
    rlo = (r1 < r2) ? r1 : r2;
    rhi = (r1 < r2) ? r2 : r1;
    clo = (c1 < c2) ? c1 : c2;
    chi = (c1 < c2) ? c2 : c1;
    x1 = 2 * r1 + 1;
    y1 = 2 * c1 + 1;
    x2 = 2 * r2 + 1;
    y2 = 2 * c2 + 1;
    if (r1 == r2) begin
      for (longint k = clo; k <= chi; k++) if (is_blocked(r1, k)) return 1'b0;
      return 1'b1;
    end
    if (c1 == c2) begin
      for (longint k = rlo; k <= rhi; k++) if (is_blocked(k, c1)) return 1'b0;
      return 1'b1;
    end
    // Row boundaries: a blocked cell is passed only at an exact corner.
    last = chi;
    for (longint k = rlo + 1; k <= rhi; k++) begin
      n = (2 * k - x2) * (y1 - y2) + y2 * (x1 - x2);
      d = 2 * (x1 - x2);
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      j = floor_quot(n, d);
      if (is_blocked(k, j)) begin
        if (n != j * d || last < j || is_blocked(k, j - 1)) return 1'b0;
      end
      last = j;
    end
    // Column boundaries, the same rule with rows and columns swapped.
    last = rhi;
    for (longint k = clo + 1; k <= chi; k++) begin
      n = (2 * k - y2) * (x1 - x2) + x2 * (y1 - y2);
      d = 2 * (y1 - y2);
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      j = floor_quot(n, d);
      if (is_blocked(j, k)) begin
        if (n != j * d || last > j || is_blocked(j - 1, k)) return 1'b0;
      end
      last = j;
    end
    return 1'b1;
  endfunction

  // Applies an accepted item to the shadow map or works out its visible bit.
  task automatic predict_item(input los_item_t it);
    if (it.command == CMD_WRITE) begin
      shadow_map[it.cell_row][it.cell_col] = it.cell_blocks;
      writes_sent++;
    end else begin
      visible_due.push_back(sight_clear(it.from_row, it.from_col, it.to_row, it.to_col));
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Presents one item, holding it steady until it is taken. Random gaps before it if may_idle is set;
  // without a gap the valid line simply stays high into the next item.
  task automatic send_item(input los_item_t it, input bit may_idle);
    while (may_idle && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.command;
    cell_row <= it.cell_row;
    cell_col <= it.cell_col;
    cell_blocks <= it.cell_blocks;
    from_row <= it.from_row;
    from_col <= it.from_col;
    to_row <= it.to_row;
    to_col <= it.to_col;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    if (it.command == CMD_QUERY && it.check && visible_due[$] !== it.visible)
      report_mismatch($sformatf("typed visible %0b differs from prediction", it.visible));
  endtask

  function automatic los_item_t write_item(int r, int c, bit b);
    los_item_t it;
    it = '{command: CMD_WRITE, cell_row: 6'(r), cell_col: 6'(c), cell_blocks: b,
           from_row: 6'($urandom), from_col: 6'($urandom), to_row: 6'($urandom),
           to_col: 6'($urandom), check: 1'b0, visible: 1'b0};
    return it;
  endfunction

  function automatic los_item_t query_item(int r1, int c1, int r2, int c2, bit chk, bit v);
    los_item_t it;
    it = '{command: CMD_QUERY, cell_row: 6'($urandom), cell_col: 6'($urandom),
           cell_blocks: 1'($urandom), from_row: 6'(r1), from_col: 6'(c1), to_row: 6'(r2),
           to_col: 6'(c2), check: chk, visible: v};
    return it;
  endfunction

  // Result side: random stalls, except during the quiet stretch; compare on acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        queries_seen++;
        if (visible === 1'b1) visible_count++;
        if (visible_due.size() == 0) report_mismatch("result with nothing expected");
        else begin
          if (visible !== visible_due[0])
            report_mismatch($sformatf("visible %b, expected %b", visible, visible_due[0]));
          void'(visible_due.pop_front());
        end
      end
      out_stall <= quiet_sink ? 1'b0 : ($urandom_range(99) < 19);
    end
  end

  // Watchdog: counts cycles in which no item crosses either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
      $display("** grid_line_of_sight_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    los_item_t directed [$];
    los_item_t it;
    int r, c, span;

    // Directed table: empty map, extremes, straight lines, corners, same cell.
    directed.push_back(query_item(0, 0, 63, 63, 1'b1, 1'b1));
    directed.push_back(query_item(63, 0, 0, 63, 1'b1, 1'b1));
    directed.push_back(query_item(5, 5, 5, 5, 1'b1, 1'b1));
    directed.push_back(write_item(5, 5, 1'b1));
    directed.push_back(query_item(5, 5, 5, 5, 1'b1, 1'b0));
    directed.push_back(query_item(5, 0, 5, 63, 1'b1, 1'b0));
    directed.push_back(query_item(0, 5, 63, 5, 1'b1, 1'b0));
    directed.push_back(query_item(4, 0, 4, 63, 1'b1, 1'b1));
    directed.push_back(write_item(63, 63, 1'b1));
    directed.push_back(query_item(0, 0, 63, 63, 1'b1, 1'b0));
    directed.push_back(write_item(0, 0, 1'b1));
    directed.push_back(query_item(0, 0, 0, 0, 1'b1, 1'b0));
    // Exact corner crossings on a diagonal with one side blocked, then both, and a shallow line.
    directed.push_back(write_item(11, 10, 1'b1));
    directed.push_back(query_item(10, 10, 12, 12, 1'b0, 1'b0));
    directed.push_back(query_item(12, 12, 10, 10, 1'b0, 1'b0));
    directed.push_back(write_item(10, 11, 1'b1));
    directed.push_back(query_item(10, 10, 12, 12, 1'b0, 1'b0));
    directed.push_back(query_item(12, 10, 10, 12, 1'b0, 1'b0));
    directed.push_back(query_item(20, 3, 23, 60, 1'b0, 1'b0));
    // Clearing writes bring blocked cells back to open.
    directed.push_back(write_item(5, 5, 1'b0));
    directed.push_back(write_item(63, 63, 1'b0));
    directed.push_back(write_item(0, 0, 1'b0));
    directed.push_back(query_item(0, 0, 63, 63, 1'b1, 1'b1));
    directed.push_back(query_item(63, 63, 0, 0, 1'b1, 1'b1));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The directed table runs without gaps on the request side.
    quiet_sink = 1'b1;
    foreach (directed[i]) send_item(directed[i], 1'b0);
    quiet_sink = 1'b0;

    // Random part: mostly a dense patch of the map so that walls and corners matter;
    // about one item in ten uses the full coordinate range instead.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_sink = (n >= 500 && n < 650);
      span = ($urandom_range(9) == 0) ? 63 : 11;
      if ($urandom_range(99) < 45) begin
        r = $urandom_range(span);
        c = $urandom_range(span);
        if (span == 63 && $urandom_range(1)) begin
          r = 63 - r;
          c = 63 - c;
        end
        it = write_item(r, c, $urandom_range(99) < 35);
      end else begin
        if (span == 63) it = query_item($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0);
        else it = query_item($urandom_range(span), $urandom_range(span),
                             $urandom_range(span), $urandom_range(span), 1'b0, 1'b0);
      end
      send_item(it, !quiet_sink);
    end
    in_valid <= 1'b0;

    while (visible_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d map writes and %0d queries, %0d of them visible",
             writes_sent, queries_seen, visible_count);
    if (mismatches == 0 && visible_due.size() == 0) begin
      $display("** grid_line_of_sight_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, visible_due.size());
      $display("** grid_line_of_sight_unit: FAILED **");
    end
    $finish;
  end

endmodule
